@@ sv/apbt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Accelerometer pitch tilt positioner: shared package
// Widths, codes, bus structures and the arctangent table used by the square
// root cells, the CORDIC cells and the top level.
// ----------------------------------------------------------------------------
package apbt_pkg;

    localparam int ACCEL_BITS      = 13;
    localparam int ANGLE_FRAC_BITS = 8;
    localparam int CORDIC_STEPS    = 16;
    localparam int PRESCALE        = 14;
    localparam int TABLE_LEN       = 24;

    localparam int PITCH_W  = 16;
    localparam int TARGET_W = 16;
    localparam int DRIVE_W  = 9;
    localparam int LEVEL_W  = 8;

    localparam int SQ_W       = 2 * ACCEL_BITS;
    localparam int ROOT_W     = ACCEL_BITS;
    localparam int SQRT_STEPS = ACCEL_BITS;
    localparam int SQRT_SW    = $clog2(SQRT_STEPS);
    localparam int CW         = ACCEL_BITS + PRESCALE + 3;
    localparam int AW         = 25;
    localparam int TABLE_IW   = $clog2(TABLE_LEN);
    localparam int ACC_SHIFT  = 16 - ANGLE_FRAC_BITS;

    localparam logic [LEVEL_W-1:0] LEVEL_RESET = LEVEL_W'(128);

    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_TICK  = 1'b1;

    typedef logic signed [ACCEL_BITS-1:0] t_accel;
    typedef logic        [SQ_W-1:0]       t_sq;
    typedef logic signed [CW-1:0]         t_cw;
    typedef logic signed [AW-1:0]         t_acc;

    localparam t_acc ROUND_HALF = t_acc'(1 << (15 - ANGLE_FRAC_BITS));
    localparam t_acc PITCH_LIM  = t_acc'(90 << ANGLE_FRAC_BITS);

    typedef struct packed {
        logic valid;
        t_sq  rem;
        t_sq  res;
    } t_sqrt_bus;

    typedef struct packed {
        logic valid;
        t_cw  cx;
        t_cw  cy;
        t_acc acc;
    } t_cord_bus;

    // Arctangent of 2^-i in degrees, Q16.
    localparam t_acc ATAN_Q16 [TABLE_LEN] = '{
        t_acc'(2949120), t_acc'(1740967), t_acc'(919879), t_acc'(466945),
        t_acc'(234379),  t_acc'(117304),  t_acc'(58666),  t_acc'(29335),
        t_acc'(14668),   t_acc'(7334),    t_acc'(3667),   t_acc'(1833),
        t_acc'(917),     t_acc'(458),     t_acc'(229),    t_acc'(115),
        t_acc'(57),      t_acc'(29),      t_acc'(14),     t_acc'(7),
        t_acc'(4),       t_acc'(2),       t_acc'(1),      t_acc'(0)
    };

    function automatic t_acc atan_q16(logic [TABLE_IW-1:0] idx);
        return ATAN_Q16[idx];
    endfunction

    function automatic t_sq sqrt_bit(logic [SQRT_SW-1:0] step);
        int sh;
        sh = 2 * (SQRT_STEPS - 1 - int'(step));
        return t_sq'(1) << sh;
    endfunction

endpackage
`default_nettype wire

@@ sv/apbt_sqrt_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Square root cell
// One digit step of the floor integer square root; the cells form a chain
// and each hands its partial remainder and root to the next every cycle.
// ----------------------------------------------------------------------------
module apbt_sqrt_cell import apbt_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic [SQRT_SW-1:0] i_step,
    input  wire t_sqrt_bus          i_bus,
    output t_sqrt_bus               o_bus
);

    t_sq  w_bit;
    t_sq  w_trial;
    t_sq  n_rem;
    t_sq  n_res;
    logic r_valid;
    t_sq  r_rem;
    t_sq  r_res;

    always_comb begin
        w_bit   = sqrt_bit(i_step);
        w_trial = i_bus.res + w_bit;
        if (i_bus.rem >= w_trial) begin
            n_rem = i_bus.rem - w_trial;
            n_res = (i_bus.res >> 1) + w_bit;
        end else begin
            n_rem = i_bus.rem;
            n_res = i_bus.res >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_bus.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_res <= n_res;
    end

    assign o_bus = '{valid: r_valid, rem: r_rem, res: r_res};

endmodule
`default_nettype wire

@@ sv/apbt_cordic_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// CORDIC vectoring cell
// One rotation step towards the X axis, accumulating the angle in Q16
// degrees; the cells form a chain and pass the vector along every cycle.
// ----------------------------------------------------------------------------
module apbt_cordic_cell import apbt_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic [TABLE_IW-1:0] i_step,
    input  wire t_cord_bus           i_bus,
    output t_cord_bus                o_bus
);

    t_cw  w_cx_sh;
    t_cw  w_cy_sh;
    t_acc w_angle;
    t_cw  n_cx;
    t_cw  n_cy;
    t_acc n_acc;
    logic r_valid;
    t_cw  r_cx;
    t_cw  r_cy;
    t_acc r_acc;

    always_comb begin
        w_cx_sh = i_bus.cx >>> i_step;
        w_cy_sh = i_bus.cy >>> i_step;
        w_angle = atan_q16(i_step);
        if (!i_bus.cy[CW-1]) begin
            n_cx  = i_bus.cx + w_cy_sh;
            n_cy  = i_bus.cy - w_cx_sh;
            n_acc = i_bus.acc + w_angle;
        end else begin
            n_cx  = i_bus.cx - w_cy_sh;
            n_cy  = i_bus.cy + w_cx_sh;
            n_acc = i_bus.acc - w_angle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_bus.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cx  <= n_cx;
        r_cy  <= n_cy;
        r_acc <= n_acc;
    end

    assign o_bus = '{valid: r_valid, cx: r_cx, cy: r_cy, acc: r_acc};

endmodule
`default_nettype wire

@@ sv/accel_pitch_bang_bang_tilt.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Accelerometer pitch bang-bang tilt positioner
// Computes the pitch of each sample through a square root cell chain and a
// CORDIC cell chain, then runs the start and tick control of the tilt drive.
//
//   Channel  Handshake                   Payload
//   input    i_in_valid / o_in_ready     func, accel_x/y/z, target_angle
//   result   o_out_valid / i_out_ready   drive, done_res, sensor_ok, pitch
//   config   i_cfg_valid / o_cfg_ready   drive_level
//
// One request is in flight at a time. It passes through the input, squaring
// and sum stages, the square root cell chain (ACCEL_BITS cells), the CORDIC
// cell chain (CORDIC_STEPS cells) and the rounding and control stages; only
// after its result is loaded into the output register is the next one taken.
// A stalled result holds the finished pitch in the rounding stage.
// Reset is synchronous and clears only control state; no clearing pass.
// ----------------------------------------------------------------------------
module accel_pitch_bang_bang_tilt import apbt_pkg::*; (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire logic                       i_func,
    input  wire logic signed [ACCEL_BITS-1:0] i_accel_x,
    input  wire logic signed [ACCEL_BITS-1:0] i_accel_y,
    input  wire logic signed [ACCEL_BITS-1:0] i_accel_z,
    input  wire logic signed [TARGET_W-1:0] i_target_angle,
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output logic signed [DRIVE_W-1:0]       o_drive,
    output logic                            o_done_res,
    output logic                            o_sensor_ok,
    output logic signed [PITCH_W-1:0]       o_pitch,
    input  wire logic                       i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire logic [LEVEL_W-1:0]         i_cfg_drive_level
);

    logic                       r_busy;
    logic                       r_v0;
    logic                       r_v1;
    logic                       r_v2;
    logic                       r_func;
    t_accel                     r_x;
    t_accel                     r_y;
    t_accel                     r_z;
    logic signed [TARGET_W-1:0] r_tgt;
    logic signed [SQ_W-1:0]     w_y_ext;
    logic signed [SQ_W-1:0]     w_z_ext;
    t_sq                        r_ysq;
    t_sq                        r_zsq;
    t_sq                        r_sq;

    t_sqrt_bus                  s_bus [SQRT_STEPS+1];
    t_cord_bus                  c_bus [CORDIC_STEPS+1];
    logic [ROOT_W-1:0]          w_root;

    t_acc                       w_rounded;
    t_acc                       w_clamped;
    logic                       r_pv;
    t_acc                       r_p;

    logic [LEVEL_W-1:0]         r_level;
    logic signed [TARGET_W-1:0] r_goal;
    logic                       r_up;
    logic                       r_fin;
    logic signed [DRIVE_W-1:0]  r_cmd;
    logic                       r_sg;
    logic                       r_ov;
    logic signed [PITCH_W-1:0]  r_opitch;

    logic signed [TARGET_W-1:0] n_goal;
    logic                       n_up;
    logic                       n_fin;
    logic signed [DRIVE_W-1:0]  n_cmd;
    logic                       n_sg;

    logic                       w_in_acc;
    logic                       w_load;
    logic                       w_fault;
    t_acc                       w_p;
    t_acc                       w_tgt_ext;
    t_acc                       w_goal_ext;
    logic signed [DRIVE_W-1:0]  w_pos_level;
    logic signed [DRIVE_W-1:0]  w_neg_level;

    assign o_in_ready  = !r_busy;
    assign o_cfg_ready = 1'b1;
    assign w_in_acc    = i_in_valid && !r_busy;
    assign w_load      = r_pv && (!r_ov || i_out_ready);

    // Input capture and squaring.
    assign w_y_ext = SQ_W'(r_y);
    assign w_z_ext = SQ_W'(r_z);

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_func <= i_func;
            r_x    <= i_accel_x;
            r_y    <= i_accel_y;
            r_z    <= i_accel_z;
            r_tgt  <= i_target_angle;
        end
        r_ysq <= t_sq'(w_y_ext * w_y_ext);
        r_zsq <= t_sq'(w_z_ext * w_z_ext);
        r_sq  <= r_ysq + r_zsq;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v0 <= w_in_acc;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
        end
    end

    // Square root chain.
    assign s_bus[0] = '{valid: r_v2, rem: r_sq, res: '0};

    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
        apbt_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_step  (SQRT_SW'(k)),
            .i_bus   (s_bus[k]),
            .o_bus   (s_bus[k+1])
        );
    end

    assign w_root = s_bus[SQRT_STEPS].res[ROOT_W-1:0];

    // CORDIC chain.
    assign c_bus[0] = '{
        valid: s_bus[SQRT_STEPS].valid,
        cx:    {{(CW-ROOT_W-PRESCALE){1'b0}}, w_root, {PRESCALE{1'b0}}},
        cy:    {{(CW-ACCEL_BITS-PRESCALE){r_x[ACCEL_BITS-1]}}, r_x, {PRESCALE{1'b0}}},
        acc:   '0
    };

    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
        apbt_cordic_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_step  (TABLE_IW'(k)),
            .i_bus   (c_bus[k]),
            .o_bus   (c_bus[k+1])
        );
    end

    // Rounding and clamping to plus or minus ninety degrees.
    always_comb begin
        w_rounded = (c_bus[CORDIC_STEPS].acc + ROUND_HALF) >>> ACC_SHIFT;
        if (w_rounded > PITCH_LIM) begin
            w_clamped = PITCH_LIM;
        end else if (w_rounded < -PITCH_LIM) begin
            w_clamped = -PITCH_LIM;
        end else begin
            w_clamped = w_rounded;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_bus[CORDIC_STEPS].valid) begin
            r_p <= w_clamped;
        end
    end

    // Drive control.
    assign w_fault     = (r_x == '0) && (r_y == '0) && (r_z == '0);
    assign w_p         = w_fault ? '0 : r_p;
    assign w_tgt_ext   = t_acc'(r_tgt);
    assign w_goal_ext  = t_acc'(r_goal);
    assign w_pos_level = signed'({1'b0, r_level});
    assign w_neg_level = -w_pos_level;

    always_comb begin
        n_goal = r_goal;
        n_up   = r_up;
        n_fin  = r_fin;
        n_cmd  = r_cmd;
        if (r_func == FUNC_START) begin
            n_goal = r_tgt;
            n_fin  = 1'b0;
            if (w_p < w_tgt_ext) begin
                n_up = 1'b1;
            end else if (w_p > w_tgt_ext) begin
                n_up = 1'b0;
            end
        end else if (!r_fin) begin
            if (r_up) begin
                if (w_p < w_goal_ext) begin
                    n_cmd = w_neg_level;
                end else begin
                    n_cmd = '0;
                    n_fin = 1'b1;
                end
            end else begin
                if (w_p > w_goal_ext) begin
                    n_cmd = w_pos_level;
                end else begin
                    n_cmd = '0;
                    n_fin = 1'b1;
                end
            end
        end
        if (w_fault) begin
            n_sg  = 1'b0;
            n_fin = 1'b1;
            n_cmd = '0;
        end else begin
            n_sg = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_pv    <= 1'b0;
            r_ov    <= 1'b0;
            r_level <= LEVEL_RESET;
            r_goal  <= '0;
            r_up    <= 1'b1;
            r_fin   <= 1'b1;
            r_cmd   <= '0;
            r_sg    <= 1'b1;
        end else begin
            if (i_cfg_valid) begin
                r_level <= i_cfg_drive_level;
            end
            if (w_in_acc) begin
                r_busy <= 1'b1;
            end else if (w_load) begin
                r_busy <= 1'b0;
            end
            if (c_bus[CORDIC_STEPS].valid) begin
                r_pv <= 1'b1;
            end else if (w_load) begin
                r_pv <= 1'b0;
            end
            if (w_load) begin
                r_ov   <= 1'b1;
                r_goal <= n_goal;
                r_up   <= n_up;
                r_fin  <= n_fin;
                r_cmd  <= n_cmd;
                r_sg   <= n_sg;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_opitch <= w_p[PITCH_W-1:0];
        end
    end

    assign o_out_valid = r_ov;
    assign o_drive     = r_cmd;
    assign o_done_res  = r_fin;
    assign o_sensor_ok = r_sg;
    assign o_pitch     = r_opitch;

endmodule
`default_nettype wire

@@ sv/apbt_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Port checker for the tilt positioner
// Watches the top level's ports for request ordering and the relation
// between the fault flag, the done flag and the drive command.
// ----------------------------------------------------------------------------
module apbt_checker import apbt_pkg::*; (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         i_in_valid,
    input wire logic                         o_in_ready,
    input wire logic                         o_out_valid,
    input wire logic                         i_out_ready,
    input wire logic signed [DRIVE_W-1:0]    o_drive,
    input wire logic                         o_done_res,
    input wire logic                         o_sensor_ok,
    input wire logic signed [PITCH_W-1:0]    o_pitch
);

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("A second request was accepted while one is in flight.");

    a_fault_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_sensor_ok) |-> o_done_res)
        else $error("A sensor fault result does not report the move as done.");

    a_done_no_drive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_done_res) |-> (o_drive == '0))
        else $error("The drive is active although the move is done.");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_pitch) && $stable(o_drive)))
        else $error("A stalled result changed before it was taken.");

endmodule

bind accel_pitch_bang_bang_tilt apbt_checker u_apbt_checker (.*);
`default_nettype wire
